>>> sv/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants of the rational arithmetic unit
// Command and status codes, widths, and the control/status bundles that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rau_pkg;

  // Signed width that a reduced result must fit
  localparam int VALUE_WIDTH = 32;
  // Magnitude width of cross products and their sum
  localparam int MAG_W       = 64;
  // One quotient bit per divider step
  localparam int DIV_STEPS   = MAG_W;
  localparam int CNT_W       = $clog2(DIV_STEPS + 1);

  localparam logic [MAG_W-1:0] MAX_POS = (MAG_W'(1) << (VALUE_WIDTH - 1)) - MAG_W'(1);

  typedef enum logic [3:0] {
    CMD_REDUCE  = 4'd0,
    CMD_ADD     = 4'd1,
    CMD_SUB     = 4'd2,
    CMD_MUL     = 4'd3,
    CMD_DIV     = 4'd4,
    CMD_LESS    = 4'd5,
    CMD_GREATER = 4'd6,
    CMD_EQUAL   = 4'd7,
    CMD_NEQUAL  = 4'd8
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_DIV_ZERO = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  // Cross product selectors
  typedef enum logic [1:0] {
    PR_LN_RD = 2'd0,
    PR_RN_LD = 2'd1,
    PR_LD_RD = 2'd2,
    PR_LN_RN = 2'd3
  } prod_t;

  typedef struct packed {
    logic  load;
    logic  mul;
    prod_t mul_sel;
    logic  setup;
    logic  gcd;
    logic  div_init;
    logic  div;
    logic  fin;
  } dp_cmd_t;

  typedef struct packed {
    logic early;
    logic gcd_done;
    logic out_full;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> sv/rau_dp.sv
// ----------------------------------------------------------------------------
// rau_dp: datapath of the rational arithmetic unit
// Operand registers, shared 32x32 multiplier, binary gcd, twin restoring
// dividers and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rau_dp (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire rau_pkg::dp_cmd_t   cmd,
  output rau_pkg::dp_stat_t       stat,
  input  wire  [3:0]              in_command,
  input  wire  [31:0]             in_left_num,
  input  wire  [31:0]             in_left_den,
  input  wire  [31:0]             in_right_num,
  input  wire  [31:0]             in_right_den,
  input  wire                     out_tready,
  output logic                    out_tvalid,
  output logic [31:0]             out_num,
  output logic [30:0]             out_den,
  output logic                    out_cmp,
  output logic [1:0]              out_status
);

  localparam int MW = rau_pkg::MAG_W;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    mag32 = v[31] ? (~v + 32'd1) : v;
  endfunction

  // Operand registers
  logic [3:0]  op_r;
  logic [31:0] ln_r, ld_r, rn_r, rd_r;

  // Cross products
  logic [MW-1:0] prod_r [4];

  // Gcd and divider state
  logic [MW-1:0] ga_r, gb_r, gn_r, gd_r;
  logic          neg_r;
  logic [MW-1:0] dv_r, qn_r, qd_r, remn_r, remd_r;

  // Early result
  logic          early_r;
  logic          e_cmp_r;
  logic [1:0]    e_st_r;

  logic          out_valid_r;
  logic [31:0]   out_num_r;
  logic [30:0]   out_den_r;
  logic          out_cmp_r;
  logic [1:0]    out_st_r;

  // Hold the request operands
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_command;
      ln_r <= in_left_num;
      ld_r <= in_left_den;
      rn_r <= in_right_num;
      rd_r <= in_right_den;
    end
  end

  // Select multiplier operands
  logic [31:0] ma, mb;
  always_comb begin
    case (cmd.mul_sel)
      rau_pkg::PR_LN_RD: begin ma = mag32(ln_r); mb = mag32(rd_r); end
      rau_pkg::PR_RN_LD: begin ma = mag32(rn_r); mb = mag32(ld_r); end
      rau_pkg::PR_LD_RD: begin ma = mag32(ld_r); mb = mag32(rd_r); end
      default:           begin ma = mag32(ln_r); mb = mag32(rn_r); end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r[cmd.mul_sel] <= MW'(ma) * MW'(mb);
    end
  end

  // Form the unreduced fraction and the early outcomes
  logic          sln, sld, srn, srd;
  logic          t1_neg, t2_neg, is_sub;
  logic [MW-1:0] t1, t2;
  logic [MW-1:0] num_mag, den_mag;
  logic          num_neg, den_neg;
  logic signed [MW-1:0] pcmp, qcmp;
  logic          early, e_cmp;
  logic [1:0]    e_st;

  always_comb begin
    sln    = ln_r[31];
    sld    = ld_r[31];
    srn    = rn_r[31];
    srd    = rd_r[31];
    is_sub = (op_r == rau_pkg::CMD_SUB);
    t1     = prod_r[rau_pkg::PR_LN_RD];
    t2     = prod_r[rau_pkg::PR_RN_LD];
    t1_neg = sln ^ srd;
    t2_neg = srn ^ sld ^ is_sub;

    num_mag = MW'(mag32(ln_r));
    num_neg = sln;
    den_mag = MW'(mag32(ld_r));
    den_neg = sld;
    case (op_r)
      rau_pkg::CMD_ADD, rau_pkg::CMD_SUB: begin
        if (t1_neg == t2_neg) begin
          num_mag = t1 + t2;
          num_neg = t1_neg;
        end else if (t1 >= t2) begin
          num_mag = t1 - t2;
          num_neg = t1_neg;
        end else begin
          num_mag = t2 - t1;
          num_neg = t2_neg;
        end
        den_mag = prod_r[rau_pkg::PR_LD_RD];
        den_neg = sld ^ srd;
      end
      rau_pkg::CMD_MUL: begin
        num_mag = prod_r[rau_pkg::PR_LN_RN];
        num_neg = sln ^ srn;
        den_mag = prod_r[rau_pkg::PR_LD_RD];
        den_neg = sld ^ srd;
      end
      rau_pkg::CMD_DIV: begin
        num_mag = t1;
        num_neg = sln ^ srd;
        den_mag = t2;
        den_neg = sld ^ srn;
      end
      default: ;
    endcase

    // Compare after moving both signs into the numerators
    pcmp = (sln ^ sld) ? -$signed(t1) : $signed(t1);
    qcmp = (srn ^ srd) ? -$signed(t2) : $signed(t2);

    early = 1'b1;
    e_cmp = 1'b0;
    e_st  = rau_pkg::ST_OK;
    if (op_r > rau_pkg::CMD_NEQUAL) begin
      e_st = rau_pkg::ST_OK;
    end else if (ld_r == 32'd0 || (op_r != rau_pkg::CMD_REDUCE && rd_r == 32'd0)) begin
      e_st = rau_pkg::ST_ZERO_DEN;
    end else if (op_r == rau_pkg::CMD_DIV && rn_r == 32'd0) begin
      e_st = rau_pkg::ST_DIV_ZERO;
    end else begin
      case (op_r)
        rau_pkg::CMD_LESS:    e_cmp = (pcmp < qcmp);
        rau_pkg::CMD_GREATER: e_cmp = (pcmp > qcmp);
        rau_pkg::CMD_EQUAL:   e_cmp = (pcmp == qcmp);
        rau_pkg::CMD_NEQUAL:  e_cmp = (pcmp != qcmp);
        default:              early = 1'b0;
      endcase
    end
  end

  // Binary gcd: shift shared factors of two out of the fraction too
  logic gcd_done;
  assign gcd_done = (ga_r == '0) || (gb_r == '0);

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      ga_r    <= num_mag;
      gb_r    <= den_mag;
      gn_r    <= num_mag;
      gd_r    <= den_mag;
      neg_r   <= num_neg ^ den_neg;
      early_r <= early;
      e_cmp_r <= e_cmp;
      e_st_r  <= e_st;
    end else if (cmd.gcd && !gcd_done) begin
      if (!ga_r[0] && !gb_r[0]) begin
        ga_r <= ga_r >> 1;
        gb_r <= gb_r >> 1;
        gn_r <= gn_r >> 1;
        gd_r <= gd_r >> 1;
      end else if (!ga_r[0]) begin
        ga_r <= ga_r >> 1;
      end else if (!gb_r[0]) begin
        gb_r <= gb_r >> 1;
      end else if (ga_r >= gb_r) begin
        ga_r <= (ga_r - gb_r) >> 1;
      end else begin
        gb_r <= (gb_r - ga_r) >> 1;
      end
    end
  end

  // Twin restoring dividers by the odd part of the gcd
  logic [MW:0]   shn, shd;
  logic          bn, bd;
  always_comb begin
    shn = {remn_r, qn_r[MW-1]};
    shd = {remd_r, qd_r[MW-1]};
    bn  = (shn >= {1'b0, dv_r});
    bd  = (shd >= {1'b0, dv_r});
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      dv_r   <= (ga_r == '0) ? gb_r : ga_r;
      qn_r   <= gn_r;
      qd_r   <= gd_r;
      remn_r <= '0;
      remd_r <= '0;
    end else if (cmd.div) begin
      remn_r <= bn ? MW'(shn - {1'b0, dv_r}) : MW'(shn);
      remd_r <= bd ? MW'(shd - {1'b0, dv_r}) : MW'(shd);
      qn_r   <= {qn_r[MW-2:0], bn};
      qd_r   <= {qd_r[MW-2:0], bd};
    end
  end

  // Range check and sign of the reduced result
  logic        fneg, ovf;
  always_comb begin
    fneg = neg_r && (qn_r != '0);
    ovf  = (qd_r > rau_pkg::MAX_POS) ||
           (qn_r > (fneg ? rau_pkg::MAX_POS + MW'(1) : rau_pkg::MAX_POS));
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fin) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      if (early_r) begin
        out_num_r <= '0;
        out_den_r <= '0;
        out_cmp_r <= e_cmp_r;
        out_st_r  <= e_st_r;
      end else if (ovf) begin
        out_num_r <= '0;
        out_den_r <= '0;
        out_cmp_r <= 1'b0;
        out_st_r  <= rau_pkg::ST_OVERFLOW;
      end else begin
        out_num_r <= fneg ? (32'd0 - qn_r[31:0]) : qn_r[31:0];
        out_den_r <= qd_r[30:0];
        out_cmp_r <= 1'b0;
        out_st_r  <= rau_pkg::ST_OK;
      end
    end
  end

  assign stat.early    = early;
  assign stat.gcd_done = gcd_done;
  assign stat.out_full = out_valid_r;

  assign out_tvalid = out_valid_r;
  assign out_num    = out_num_r;
  assign out_den    = out_den_r;
  assign out_cmp    = out_cmp_r;
  assign out_status = out_st_r;

endmodule

`default_nettype wire

>>> sv/rau_ctrl.sv
// ----------------------------------------------------------------------------
// rau_ctrl: sequencer of the rational arithmetic unit
// Steps one request: products, setup, gcd and division unless early, output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rau_ctrl (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_fire,
  input  wire                     out_tready,
  output logic                    in_tready,
  output rau_pkg::dp_cmd_t        cmd,
  input  wire rau_pkg::dp_stat_t  stat
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MUL   = 6'b000010,
    S_SETUP = 6'b000100,
    S_GCD   = 6'b001000,
    S_DIV   = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t                     state_r, state_nxt;
  logic [1:0]                 mul_cnt_r, mul_cnt_nxt;
  logic [rau_pkg::CNT_W-1:0]  div_cnt_r, div_cnt_nxt;

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    mul_cnt_nxt = mul_cnt_r;
    div_cnt_nxt = div_cnt_r;
    cmd         = '0;
    cmd.mul_sel = rau_pkg::prod_t'(mul_cnt_r);
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load    = 1'b1;
          mul_cnt_nxt = 2'd0;
          state_nxt   = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul     = 1'b1;
        mul_cnt_nxt = mul_cnt_r + 2'd1;
        if (mul_cnt_r == 2'd3) begin
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = stat.early ? S_FIN : S_GCD;
      end
      S_GCD: begin
        if (stat.gcd_done) begin
          cmd.div_init = 1'b1;
          div_cnt_nxt  = '0;
          state_nxt    = S_DIV;
        end else begin
          cmd.gcd = 1'b1;
        end
      end
      S_DIV: begin
        cmd.div     = 1'b1;
        div_cnt_nxt = div_cnt_r + rau_pkg::CNT_W'(1);
        if (div_cnt_r == rau_pkg::CNT_W'(rau_pkg::DIV_STEPS - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!stat.out_full || out_tready) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      mul_cnt_r <= '0;
      div_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      mul_cnt_r <= mul_cnt_nxt;
      div_cnt_r <= div_cnt_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  a_early_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SETUP && stat.early) |=> (state_r == S_FIN))
    else $error("early outcome did not go straight to output");

  a_div_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    div_cnt_r <= rau_pkg::CNT_W'(rau_pkg::DIV_STEPS))
    else $error("divider step count out of range");

  a_gcd_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> stat.gcd_done)
    else $error("gcd operands changed during division");

endmodule

`default_nettype wire

>>> sv/rational_arith_unit_core.sv
// ----------------------------------------------------------------------------
// rational_arith_unit_core: exact signed fraction arithmetic and compare
// Reduce, add, subtract, multiply, divide and compare two fractions, with
// gcd reduction and flags for zero denominators, divide by zero and overflow.
// ----------------------------------------------------------------------------
//  channel | direction | tdata                              | tuser
//  in_     | slave     | left_num,left_den,right_num,right_den | command
//  out_    | master    | out_num,out_den,compare_true       | status
//
//  A compare or flagged request reaches the output register after the cross
//  products, setup and output steps; arithmetic adds the gcd steps (one binary
//  gcd step per cycle), the start of the dividers and the divider steps.
//  One request is in flight at a time; in_tready is high only when idle.
//  A finished result waits in the output register while the next request is
//  taken; a stalled output holds the block only at its final step.
//  rst_n is synchronous and active low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rational_arith_unit_core (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  input  wire  [127:0] in_tdata,   // left_num, left_den, right_num, right_den
  input  wire  [3:0]   in_tuser,   // command
  output logic         out_tvalid,
  input  wire          out_tready,
  output logic [63:0]  out_tdata,  // out_num, out_den, compare_true
  output logic [1:0]   out_tuser   // status
);

  rau_pkg::dp_cmd_t  cmd;
  rau_pkg::dp_stat_t stat;
  logic [31:0]       o_num;
  logic [30:0]       o_den;
  logic              o_cmp;
  logic [1:0]        o_st;

  rau_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_tvalid && in_tready),
    .out_tready (out_tready),
    .in_tready  (in_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  rau_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_command   (in_tuser),
    .in_left_num  (in_tdata[31:0]),
    .in_left_den  (in_tdata[63:32]),
    .in_right_num (in_tdata[95:64]),
    .in_right_den (in_tdata[127:96]),
    .out_tready   (out_tready),
    .out_tvalid   (out_tvalid),
    .out_num      (o_num),
    .out_den      (o_den),
    .out_cmp      (o_cmp),
    .out_status   (o_st)
  );

  assign out_tdata = {o_cmp, o_den, o_num};
  assign out_tuser = o_st;

endmodule

`default_nettype wire

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench for rational_arith_unit_core
// Drives fraction requests on the input stream, predicts each reduced result
// or compare outcome in the bench, and checks every response in order under
// random source and sink stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb;

  typedef struct {
    logic signed [31:0] num;
    logic [30:0]        den;
    logic               cmp;
    rau_pkg::status_t   st;
  } frac_result_t;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 250;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;
  logic [3:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [63:0]  out_tdata;
  logic [1:0]   out_tuser;

  frac_result_t expected_q[$];
  int           error_count = 0;
  int           results_checked = 0;
  int           requests_sent = 0;
  int           cmd_count[16];
  int           status_count[4];
  int           tx_idle_pct = 0;
  int           rx_idle_pct = 0;
  int           idle_cycles = 0;

  rational_arith_unit_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #5 clk = ~clk;

  // Reduce a sign-magnitude fraction by its gcd and range-check the result
  function automatic frac_result_t reduce_fraction(bit nneg, logic [63:0] nmag,
                                                   bit dneg, logic [63:0] dmag);
    frac_result_t r;
    logic [63:0] a, b, t, nm, dm;
    bit neg;
    a = nmag;
    b = dmag;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    nm = nmag / a;
    dm = dmag / a;
    neg = (nneg != dneg) && nm != 0;
    r = '{num: '0, den: '0, cmp: 1'b0, st: rau_pkg::ST_OK};
    if (dm > rau_pkg::MAX_POS ||
        nm > (neg ? rau_pkg::MAX_POS + 64'd1 : rau_pkg::MAX_POS)) begin
      r.st = rau_pkg::ST_OVERFLOW;
    end else begin
      r.num = neg ? 32'(64'd0 - nm) : nm[31:0];
      r.den = dm[30:0];
    end
    return r;
  endfunction

  function automatic logic [63:0] mag_of(logic signed [31:0] v);
    longint x;
    x = v;
    return x < 0 ? 64'(-x) : 64'(x);
  endfunction

  // Expected response for one fraction request
  function automatic frac_result_t predict_fraction(logic [3:0] cmd,
      logic signed [31:0] ln, logic signed [31:0] ld,
      logic signed [31:0] rn, logic signed [31:0] rd);
    frac_result_t r;
    logic [63:0] pm, qm, sm, dm;
    bit pn, qn, sn, dn;
    longint lnx, ldx, rnx, rdx, p, q;
    r = '{num: '0, den: '0, cmp: 1'b0, st: rau_pkg::ST_OK};
    if (cmd > rau_pkg::CMD_NEQUAL) return r;
    if (ld == 0 || (cmd != rau_pkg::CMD_REDUCE && rd == 0)) begin
      r.st = rau_pkg::ST_ZERO_DEN;
      return r;
    end
    if (cmd == rau_pkg::CMD_DIV && rn == 0) begin
      r.st = rau_pkg::ST_DIV_ZERO;
      return r;
    end
    case (cmd)
      rau_pkg::CMD_REDUCE: begin
        r = reduce_fraction(ln < 0, mag_of(ln), ld < 0, mag_of(ld));
      end
      rau_pkg::CMD_ADD, rau_pkg::CMD_SUB: begin
        pm = mag_of(ln) * mag_of(rd);
        pn = ((ln < 0) != (rd < 0)) && pm != 0;
        qm = mag_of(rn) * mag_of(ld);
        qn = ((rn < 0) != (ld < 0)) && qm != 0;
        if (cmd == rau_pkg::CMD_SUB && qm != 0) qn = !qn;
        if (pn == qn) begin
          sm = pm + qm;
          sn = pn;
        end else if (pm >= qm) begin
          sm = pm - qm;
          sn = pn;
        end else begin
          sm = qm - pm;
          sn = qn;
        end
        if (sm == 0) sn = 1'b0;
        dm = mag_of(ld) * mag_of(rd);
        dn = (ld < 0) != (rd < 0);
        r = reduce_fraction(sn, sm, dn, dm);
      end
      rau_pkg::CMD_MUL: begin
        r = reduce_fraction((ln < 0) != (rn < 0), mag_of(ln) * mag_of(rn),
                            (ld < 0) != (rd < 0), mag_of(ld) * mag_of(rd));
      end
      rau_pkg::CMD_DIV: begin
        r = reduce_fraction((ln < 0) != (rd < 0), mag_of(ln) * mag_of(rd),
                            (ld < 0) != (rn < 0), mag_of(ld) * mag_of(rn));
      end
      default: begin
        lnx = ln; ldx = ld; rnx = rn; rdx = rd;
        if (ldx < 0) begin lnx = -lnx; ldx = -ldx; end
        if (rdx < 0) begin rnx = -rnx; rdx = -rdx; end
        p = lnx * rdx;
        q = rnx * ldx;
        case (cmd)
          rau_pkg::CMD_LESS:    r.cmp = p < q;
          rau_pkg::CMD_GREATER: r.cmp = p > q;
          rau_pkg::CMD_EQUAL:   r.cmp = p == q;
          default:              r.cmp = p != q;
        endcase
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    error_count++;
    $display("[%0t] MISMATCH %s: got %0d expected %0d", $realtime, what, got, want);
  endtask

  // Send one request, idling the source at random first
  task automatic send_request(logic [3:0] cmd, logic signed [31:0] ln,
      logic signed [31:0] ld, logic signed [31:0] rn, logic signed [31:0] rd);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {rd, rn, ld, ln};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_q.push_back(predict_fraction(cmd, ln, ld, rn, rd));
    requests_sent++;
    cmd_count[cmd]++;
    @(negedge clk);
  endtask

  // Check each accepted response against the oldest prediction
  always @(posedge clk) begin
    frac_result_t want;
    if (out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected response, pending", 0, 0);
      end else begin
        want = expected_q.pop_front();
        results_checked++;
        status_count[want.st]++;
        if ($signed(out_tdata[31:0]) != want.num)
          report_mismatch("out_num", $signed(out_tdata[31:0]), want.num);
        if (out_tdata[62:32] != want.den)
          report_mismatch("out_den", out_tdata[62:32], want.den);
        if (out_tdata[63] != want.cmp)
          report_mismatch("compare_true", out_tdata[63], want.cmp);
        if (out_tuser != want.st)
          report_mismatch("status", out_tuser, want.st);
      end
    end
  end

  // Stall the sink at random
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // End the run if no request or response moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(4))
      0: return $signed(32'($urandom_range(40))) - 32'sd20;
      1: return $urandom;
      2: case ($urandom_range(4))
           0: return 32'h8000_0000;
           1: return 32'h7fff_ffff;
           2: return -32'sd1;
           3: return 32'sd1;
           default: return 32'sd0;
         endcase
      3: return $signed(16'($urandom));
      default: return $signed(32'($urandom_range(2000))) - 32'sd1000;
    endcase
  endfunction

  function automatic logic signed [31:0] pick_den();
    logic signed [31:0] v;
    if ($urandom_range(99) < 3) return 32'sd0;
    v = pick_value();
    return v == 0 ? 32'sd7 : v;
  endfunction

  task automatic test_directed();
    logic signed [31:0] vmin, vmax;
    vmin = 32'h8000_0000;
    vmax = 32'h7fff_ffff;
    send_request(rau_pkg::CMD_REDUCE, 32'sd6, -32'sd4, vmin, 32'sd0);   // right side ignored
    send_request(rau_pkg::CMD_REDUCE, 32'sd0, -32'sd9, 32'sd0, 32'sd0); // zero gives 0/1
    send_request(rau_pkg::CMD_REDUCE, vmin, -32'sd1, 32'sd1, 32'sd1);   // overflow on negate
    send_request(rau_pkg::CMD_REDUCE, vmin, vmax, 32'sd1, 32'sd1);
    send_request(rau_pkg::CMD_REDUCE, vmin, vmin, 32'sd1, 32'sd1);
    send_request(rau_pkg::CMD_REDUCE, 32'sd5, 32'sd0, 32'sd1, 32'sd1);  // zero denominator
    send_request(rau_pkg::CMD_ADD, 32'sd1, 32'sd2, 32'sd1, 32'sd3);
    send_request(rau_pkg::CMD_ADD, vmax, 32'sd1, vmax, 32'sd1);         // overflow
    send_request(rau_pkg::CMD_ADD, 32'sd1, 32'sd2, 32'sd1, 32'sd0);     // zero right den
    send_request(rau_pkg::CMD_SUB, 32'sd1, 32'sd2, 32'sd1, 32'sd2);     // zero result
    send_request(rau_pkg::CMD_SUB, vmin, 32'sd1, vmax, -32'sd1);
    send_request(rau_pkg::CMD_MUL, vmin, vmin, vmin, vmin);
    send_request(rau_pkg::CMD_MUL, vmin, 32'sd1, -32'sd1, 32'sd1);
    send_request(rau_pkg::CMD_DIV, 32'sd3, 32'sd4, 32'sd0, 32'sd5);     // divide by zero
    send_request(rau_pkg::CMD_DIV, 32'sd3, -32'sd4, -32'sd9, 32'sd8);
    send_request(rau_pkg::CMD_DIV, 32'sd0, 32'sd4, 32'sd0, 32'sd0);     // zero den first
    send_request(rau_pkg::CMD_LESS, vmin, 32'sd1, vmax, 32'sd1);
    send_request(rau_pkg::CMD_LESS, 32'sd1, -32'sd2, 32'sd1, 32'sd2);
    send_request(rau_pkg::CMD_GREATER, vmax, vmin, vmin, vmax);
    send_request(rau_pkg::CMD_EQUAL, 32'sd2, 32'sd4, -32'sd3, -32'sd6);
    send_request(rau_pkg::CMD_NEQUAL, 32'sd2, 32'sd4, 32'sd3, 32'sd6);
    send_request(rau_pkg::CMD_NEQUAL, vmin, vmin, 32'sd1, 32'sd1);
    send_request(4'd9, vmin, 32'sd0, 32'sd1, 32'sd1);                   // unknown command
    send_request(4'd15, vmax, vmax, vmax, vmax);
  endtask

  // Random requests; some use a scaled copy so equal compares come out true
  task automatic test_random(int n);
    logic [3:0] cmd;
    logic signed [31:0] ln, ld, rn, rd, k;
    repeat (n) begin
      cmd = ($urandom_range(99) < 5) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8));
      ln = pick_value();
      ld = pick_den();
      rn = pick_value();
      rd = pick_den();
      if ($urandom_range(3) == 0) begin
        k  = $signed(32'($urandom_range(12))) - 32'sd6;
        if (k == 0) k = 32'sd3;
        ln = $signed(32'($urandom_range(2000))) - 32'sd1000;
        ld = $signed(32'($urandom_range(1000, 1)));
        rn = ln * k;
        rd = ld * k;
      end
      send_request(cmd, ln, ld, rn, rd);
    end
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    foreach (cmd_count[i]) cmd_count[i] = 0;
    foreach (status_count[i]) status_count[i] = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    tx_idle_pct = 22;
    rx_idle_pct = 61;
    test_directed();
    test_random(510);
    tx_idle_pct = 61;
    rx_idle_pct = 22;
    test_random(510);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random(510);
    wait_drain();
    $display("Covered %0d requests (%0d reduce, %0d add/sub, %0d mul/div, %0d compare)",
             requests_sent, cmd_count[rau_pkg::CMD_REDUCE],
             cmd_count[rau_pkg::CMD_ADD] + cmd_count[rau_pkg::CMD_SUB],
             cmd_count[rau_pkg::CMD_MUL] + cmd_count[rau_pkg::CMD_DIV],
             cmd_count[rau_pkg::CMD_LESS] + cmd_count[rau_pkg::CMD_GREATER]
             + cmd_count[rau_pkg::CMD_EQUAL] + cmd_count[rau_pkg::CMD_NEQUAL]);
    $display("Checked %0d responses: %0d ok, %0d zero den, %0d div zero, %0d overflow",
             results_checked, status_count[rau_pkg::ST_OK],
             status_count[rau_pkg::ST_ZERO_DEN],
             status_count[rau_pkg::ST_DIV_ZERO], status_count[rau_pkg::ST_OVERFLOW]);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> rational_arith_unit_core.f
sv/rau_pkg.sv
sv/rau_dp.sv
sv/rau_ctrl.sv
sv/rational_arith_unit_core.sv
tb/tb.sv
